// ===== src/plpls_pkg.sv =====
package plpls_pkg;

    // defaults for the top level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int SAMPLES_DEF    = 256;

    localparam int POS_W = 16;
    localparam int VAL_W = 16;
    localparam int IDX_W = 8;
    localparam int OP_W  = 2;

    // shared serial divider widths
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_EVAL   = 2'd2;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    // one stored control point
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] c;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] a;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    function automatic logic [VAL_W-1:0] chan(input t_entry e, input logic [1:0] k);
        logic [VAL_W-1:0] v;
        case (k)
            2'd0:    v = e.a;
            2'd1:    v = e.b;
            default: v = e.c;
        endcase
        return v;
    endfunction

endpackage

// ===== src/plpls_mem.sv =====
module plpls_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  plpls_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output plpls_pkg::t_entry o_rd_data
);
    import plpls_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/plpls_div.sv =====
module plpls_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plpls_pkg::t_div_req i_req,
    output plpls_pkg::t_div_rsp o_rsp
);
    import plpls_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [DIV_DW:0] w_shift;
    logic [DIV_DW:0] w_sub;
    logic            w_ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NW-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_sub   = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo <= i_req.num;
                r_rem <= '0;
                r_den <= i_req.den;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= w_ge ? w_sub[DIV_DW-1:0] : w_shift[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== src/piecewise_linear_lut_sampler.sv =====
// piecewise-linear curve sampler. a word with start high is taken at a clock
// edge where busy is low: clear and append finish at that edge and never
// raise busy; evaluate ends with exactly one result word on the o_result_*
// ports, marked by o_strobe for a single cycle, which the receiver must take
// then since it cannot hold it off. with no points stored busy never rises and
// the strobe comes in the first cycle after the request with status set; with
// one point busy is high for one cycle and the strobe comes as it falls.
// otherwise the scan ends on the point at index hi (1 to MAX_POINTS-1), and
// the strobe comes as busy falls. the sample position divide is skipped when
// the last position is not above the first. a flat or falling segment skips
// the division and the blend. the sample position is formed with a constant
// reciprocal multiply for the division by SAMPLES-1 (states S_XGO and
// S_XDIV); the scan reads the point memory one entry a cycle up to the first
// point at or above the sample position or the last point; the segment
// fraction goes through a bit-serial divider, one quotient bit a cycle over
// 32 bits; interpolation then runs one channel at a time through a single
// multiplier, in states S_MUL and S_ADD for each channel. a new word can be
// taken in the cycle the strobe is high. points live in a single-port-read
// memory with registered read data and are never cleared
module piecewise_linear_lut_sampler #(
    parameter int MAX_POINTS = plpls_pkg::MAX_POINTS_DEF,
    parameter int SAMPLES    = plpls_pkg::SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  plpls_pkg::t_op                      i_operation,
    input  logic [plpls_pkg::POS_W-1:0]         i_position,
    input  logic [plpls_pkg::VAL_W-1:0]         i_value_a,
    input  logic [plpls_pkg::VAL_W-1:0]         i_value_b,
    input  logic [plpls_pkg::VAL_W-1:0]         i_value_c,
    input  logic [plpls_pkg::IDX_W-1:0]         i_sample_index,
    output logic                                o_strobe,
    output logic [plpls_pkg::VAL_W-1:0]         o_result_a,
    output logic [plpls_pkg::VAL_W-1:0]         o_result_b,
    output logic [plpls_pkg::VAL_W-1:0]         o_result_c,
    output logic [plpls_pkg::IDX_W-1:0]         o_result_index,
    output logic                                o_status
);
    import plpls_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // sample position divide by SAMPLES-1 as a multiply by a rounded-up
    // reciprocal, exact for every numerator below 2^XNUM_W
    localparam int XDEN   = SAMPLES - 1;
    localparam int XNUM_W = IDX_W + POS_W;
    localparam int XSUM_W = XNUM_W + 1;
    localparam int XSH    = XNUM_W + $clog2(XDEN);
    localparam int XREC_W = XNUM_W + 2;
    localparam int XPRD_W = XNUM_W + XREC_W;
    localparam logic [XREC_W-1:0] XREC =
        XREC_W'(((64'd1 << XSH) + 64'(XDEN) - 64'd1) / 64'(XDEN));

    typedef enum logic [3:0] {
        S_IDLE, S_ONE, S_FIRST, S_LAST, S_XGO, S_XDIV, S_SCAN0, S_SCAN,
        S_SEG, S_TGO, S_TDIV, S_MUL, S_ADD
    } t_state;

    t_state r_state;

    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_hi;
    t_entry             r_lo;      // entry just below the scan position
    t_entry             r_hient;   // entry that ended the scan
    logic [POS_W-1:0]   r_first;
    logic [POS_W-1:0]   r_last;
    logic [POS_W-1:0]   r_x;       // sample position
    logic [XNUM_W-1:0]  r_xnum;    // sample index times span
    logic [XPRD_W-1:0]  r_xprod;   // same, times the reciprocal
    logic [DIV_NW-1:0]  r_num;
    logic [DIV_DW-1:0]  r_den;
    logic [VAL_W:0]     r_d;       // fraction 0..65536
    logic [1:0]         r_k;       // channel being blended
    logic signed [VAL_W+VAL_W+2:0] r_prod;
    logic [VAL_W-1:0]   r_res [3];
    logic [IDX_W-1:0]   r_idx;

    logic               r_strobe;
    logic [VAL_W-1:0]   r_out_a;
    logic [VAL_W-1:0]   r_out_b;
    logic [VAL_W-1:0]   r_out_c;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_status;

    // memory port
    logic       w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry     w_wr_data;
    logic       w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry     w_rd_data;

    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    logic       w_accept;
    logic       w_full;
    logic [AW-1:0] w_last_addr;
    logic       w_stop;
    logic [XNUM_W-1:0] w_xq;
    logic [XSUM_W-1:0] w_xsum;
    logic [POS_W-1:0]  w_seg;
    logic [POS_W-1:0]  w_t;
    logic [VAL_W-1:0]  w_lo_k;
    logic [VAL_W-1:0]  w_hi_k;
    logic signed [VAL_W:0]   w_diff;
    logic signed [VAL_W+2:0] w_mix;

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_full      = (r_count == CW'(MAX_POINTS));
    assign w_last_addr = AW'(r_count - 1'b1);
    assign busy        = (r_state != S_IDLE);

    // append writes at the fill position
    assign w_wr_en   = w_accept && (i_operation == OP_APPEND) && !w_full;
    assign w_wr_addr = r_count[AW-1:0];
    assign w_wr_data = '{pos: i_position, c: i_value_c, b: i_value_b, a: i_value_a};

    // read address by phase; the scan reads one entry ahead each cycle
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                w_rd_en = w_accept && (i_operation == OP_EVAL);
            end
            S_FIRST: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_last_addr;
            end
            S_SCAN0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(1);
            end
            S_SCAN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_hi + 1'b1;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    assign w_div_req.start = (r_state == S_TGO);
    assign w_div_req.num   = r_num;
    assign w_div_req.den   = r_den;

    // scan ends on the last point or the first point at or above x
    assign w_stop = (r_hi == w_last_addr) || (w_rd_data.pos >= r_x);

    // quotient of the sample position divide and its offset from the first point
    assign w_xq   = XNUM_W'(r_xprod >> XSH);
    assign w_xsum = XSUM_W'(r_first) + XSUM_W'(w_xq);

    // segment length and clamped offset into it
    always_comb begin
        w_seg = r_hient.pos - r_lo.pos;
        w_t   = (r_x > r_lo.pos) ? (r_x - r_lo.pos) : '0;
        if (w_t > w_seg) begin
            w_t = w_seg;
        end
    end

    // blend as lo + (hi - lo) * d / 65536, floor throughout
    assign w_lo_k = chan(r_lo, r_k);
    assign w_hi_k = chan(r_hient, r_k);
    assign w_diff = $signed({1'b0, w_hi_k}) - $signed({1'b0, w_lo_k});
    assign w_mix  = $signed({3'b000, w_lo_k}) + r_prod[VAL_W+VAL_W+2:VAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx <= i_sample_index;
                        case (i_operation)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (!w_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_EVAL: begin
                                if (r_count == '0) begin
                                    r_strobe     <= 1'b1;
                                    r_out_a      <= '0;
                                    r_out_b      <= '0;
                                    r_out_c      <= '0;
                                    r_out_idx    <= i_sample_index;
                                    r_out_status <= ST_EMPTY;
                                end else if (r_count == CW'(1)) begin
                                    r_state <= S_ONE;
                                end else begin
                                    r_state <= S_FIRST;
                                end
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_ONE: begin
                    r_strobe     <= 1'b1;
                    r_out_a      <= w_rd_data.a;
                    r_out_b      <= w_rd_data.b;
                    r_out_c      <= w_rd_data.c;
                    r_out_idx    <= r_idx;
                    r_out_status <= ST_OK;
                    r_state      <= S_IDLE;
                end
                S_FIRST: begin
                    r_lo    <= w_rd_data;
                    r_first <= w_rd_data.pos;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_last <= w_rd_data.pos;
                    if (w_rd_data.pos <= r_first) begin
                        r_x     <= w_rd_data.pos;
                        r_state <= S_SCAN0;
                    end else begin
                        r_xnum  <= XNUM_W'(r_idx) * XNUM_W'(w_rd_data.pos - r_first);
                        r_state <= S_XGO;
                    end
                end
                S_XGO: begin
                    r_xprod <= r_xnum * XREC;
                    r_state <= S_XDIV;
                end
                S_XDIV: begin
                    r_x     <= (w_xsum > XSUM_W'(r_last)) ? r_last : w_xsum[POS_W-1:0];
                    r_state <= S_SCAN0;
                end
                S_SCAN0: begin
                    r_hi    <= AW'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_stop) begin
                        r_hient <= w_rd_data;
                        r_state <= S_SEG;
                    end else begin
                        r_lo <= w_rd_data;
                        r_hi <= r_hi + 1'b1;
                    end
                end
                S_SEG: begin
                    if (r_hient.pos <= r_lo.pos) begin
                        // flat or descending segment: lower point's values
                        r_strobe     <= 1'b1;
                        r_out_a      <= r_lo.a;
                        r_out_b      <= r_lo.b;
                        r_out_c      <= r_lo.c;
                        r_out_idx    <= r_idx;
                        r_out_status <= ST_OK;
                        r_state      <= S_IDLE;
                    end else begin
                        r_num   <= {w_t, {(DIV_NW - POS_W){1'b0}}};
                        r_den   <= w_seg;
                        r_state <= S_TGO;
                    end
                end
                S_TGO: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (w_div_rsp.done) begin
                        r_d     <= w_div_rsp.quo[VAL_W:0];
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_diff * $signed({1'b0, r_d});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_res[r_k] <= w_mix[VAL_W-1:0];
                    if (r_k == 2'd2) begin
                        r_strobe     <= 1'b1;
                        r_out_a      <= r_res[0];
                        r_out_b      <= r_res[1];
                        r_out_c      <= w_mix[VAL_W-1:0];
                        r_out_idx    <= r_idx;
                        r_out_status <= ST_OK;
                        r_state      <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result_a     = r_out_a;
    assign o_result_b     = r_out_b;
    assign o_result_c     = r_out_c;
    assign o_result_index = r_out_idx;
    assign o_status       = r_out_status;

    plpls_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    plpls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

// ===== src/plpls_chk.sv =====
module plpls_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input plpls_pkg::t_op                i_operation,
    input logic                          o_strobe,
    input logic [plpls_pkg::VAL_W-1:0]   o_result_a,
    input logic [plpls_pkg::VAL_W-1:0]   o_result_b,
    input logic [plpls_pkg::VAL_W-1:0]   o_result_c,
    input logic                          o_status
);
    import plpls_pkg::*;

    // clear and append never produce a result word
    a_no_result_for_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != OP_EVAL)) |=> !o_strobe)
        else $error("result word after a clear or append");

    // an evaluate either answers at once or goes busy
    a_eval_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_EVAL)) |=> (busy || o_strobe))
        else $error("evaluate neither answered nor started");

    // a result word comes with the return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while still busy");

    // empty status carries zero channels
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EMPTY)) |->
            ((o_result_a == '0) && (o_result_b == '0) && (o_result_c == '0)))
        else $error("empty result with nonzero channels");

endmodule

bind piecewise_linear_lut_sampler plpls_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_strobe    (o_strobe),
    .o_result_a  (o_result_a),
    .o_result_b  (o_result_b),
    .o_result_c  (o_result_c),
    .o_status    (o_status)
);
